// ----- rtl/fct_pkg.sv -----
// ----------------------------------------------------------------------------
// fct_pkg
// shared types, codes and plane tables of the frustum cull test core
// ----------------------------------------------------------------------------
package fct_pkg;

	localparam int WordW = 32;
	localparam int RawW  = 33;
	localparam int SumW  = 66;
	localparam int LenW  = 34;
	localparam int AccW  = 66;

	localparam int NumPlanes = 6;

	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_BOX    = 2'd1;
	localparam logic [1:0] KIND_SPHERE = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	typedef struct packed {
		logic signed [WordW-1:0] r3;
		logic signed [WordW-1:0] r2;
		logic signed [WordW-1:0] r1;
		logic signed [WordW-1:0] r0;
	} column_t;

	typedef struct packed {
		logic signed [WordW-1:0] d;
		logic signed [WordW-1:0] nz;
		logic signed [WordW-1:0] ny;
		logic signed [WordW-1:0] nx;
	} plane_t;

	// near plane is row2 alone, all others add row3
	function automatic logic plane_uses_row3(input logic [2:0] p);
		return (p != 3'd4);
	endfunction

	function automatic logic [1:0] plane_other_row(input logic [2:0] p);
		logic [1:0] r;
		unique case (p)
			3'd0, 3'd1: r = 2'd0;
			3'd2, 3'd3: r = 2'd1;
			default:    r = 2'd2;
		endcase
		return r;
	endfunction

	function automatic logic plane_other_neg(input logic [2:0] p);
		return p[0];
	endfunction

	function automatic logic [WordW-1:0] sat_raw(input logic signed [RawW-1:0] v);
		logic [WordW-1:0] r;
		if (v > $signed(RawW'(33'h0_7FFF_FFFF)))
			r = 32'h7FFF_FFFF;
		else if (v < $signed(RawW'(33'h1_8000_0000)))
			r = 32'h8000_0000;
		else
			r = v[WordW-1:0];
		return r;
	endfunction

endpackage

// ----- rtl/frustum_cull_test_core.sv -----
// ----------------------------------------------------------------------------
// frustum_cull_test_core
// view frustum culling of boxes and spheres against six derived clip planes
// ----------------------------------------------------------------------------
// a box or sphere test reads each plane, adds its three products to d and checks the sign
// a column load stores the column and then derives all six planes from the matrix
// the datapath holds a 32x32 test multiplier, a 33-bit squarer, a bit-serial root and divider
// busy stays high for the whole item; results appear for one cycle on done
// reset clears the matrix and planes to zero through column and plane valid bits
// ----------------------------------------------------------------------------
module frustum_cull_test_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [1:0]  column_index,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_z,
	input  logic signed [31:0] a_w,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	output logic        done,
	output logic        visible,
	output logic        test_kind
);
	import fct_pkg::*;

	localparam int NumW = RawW + FRAC_BITS + 1;
	localparam int CntW = $clog2(NumW + 1);
	localparam logic [NumW-1:0] QMaxPos = NumW'(32'h7FFF_FFFF);
	localparam logic [NumW-1:0] QMaxNeg = NumW'(32'h8000_0000);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_D_RD   = 4'd1;
	localparam logic [3:0] ST_D_RAW  = 4'd2;
	localparam logic [3:0] ST_D_SQ   = 4'd3;
	localparam logic [3:0] ST_D_CHK  = 4'd4;
	localparam logic [3:0] ST_D_SQRT = 4'd5;
	localparam logic [3:0] ST_D_DIVI = 4'd6;
	localparam logic [3:0] ST_D_DIV  = 4'd7;
	localparam logic [3:0] ST_D_WR   = 4'd8;
	localparam logic [3:0] ST_T_RD   = 4'd9;
	localparam logic [3:0] ST_T_D    = 4'd10;
	localparam logic [3:0] ST_T_MUL  = 4'd11;
	localparam logic [3:0] ST_T_ACC  = 4'd12;
	localparam logic [3:0] ST_T_CHK  = 4'd13;
	localparam logic [3:0] ST_EMIT   = 4'd14;

	logic [3:0] state_q;

	column_t mat_mem [4];
	logic [3:0] mat_vld_q;
	column_t mat_rd_q;

	plane_t plane_mem [NumPlanes];
	logic [NumPlanes-1:0] plane_vld_q;
	plane_t pl_rd_q;

	logic [1:0] kind_q;
	logic signed [WordW-1:0] ax_q, ay_q, az_q, aw_q, bx_q, by_q, bz_q;

	logic [2:0] p_q;
	logic [2:0] c_q;

	logic signed [RawW-1:0] raw_q [4];
	logic [RawW-1:0] mag_q;
	logic [SumW-1:0] sum_q;
	logic [LenW-1:0] len_q;
	logic [NumW-1:0] num_q;
	logic [LenW:0] rem_q;
	logic [CntW-1:0] cnt_q;
	logic [WordW-1:0] res_q [4];

	logic signed [AccW-1:0] acc_q;
	logic signed [2*WordW-1:0] prod_q;
	logic vis_q;

	logic done_q, visible_q, test_kind_q;

	logic accept;
	logic sq_start, sq_done;
	logic [LenW-1:0] sq_root;

	logic signed [WordW-1:0] other_w;
	logic signed [RawW-1:0] raw_w;
	logic [SumW-1:0] sq_w;
	logic signed [RawW-1:0] raw_sel;
	logic [RawW-1:0] raw_mag;
	logic [LenW:0] rem_try;
	logic div_ge;
	logic [NumW-1:0] num_next;
	logic [WordW-1:0] quot_sat;
	logic signed [WordW-1:0] n_sel, pt_sel;
	logic signed [2*WordW-1:0] mul_w;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// plane row arithmetic
	always_comb begin
		unique case (plane_other_row(p_q))
			2'd0:    other_w = mat_rd_q.r0;
			2'd1:    other_w = mat_rd_q.r1;
			default: other_w = mat_rd_q.r2;
		endcase
		raw_w = plane_other_neg(p_q) ? -RawW'(other_w) : RawW'(other_w);
		if (plane_uses_row3(p_q))
			raw_w = raw_w + RawW'(mat_rd_q.r3);
	end

	assign sq_w    = SumW'(mag_q) * SumW'(mag_q);
	assign raw_sel = raw_q[c_q[1:0]];
	assign raw_mag = raw_sel[RawW-1] ? RawW'(-raw_sel) : RawW'(raw_sel);

	// restoring divide step
	assign rem_try  = {rem_q[LenW-1:0], num_q[NumW-1]};
	assign div_ge   = (rem_try >= {1'b0, len_q});
	assign num_next = {num_q[NumW-2:0], div_ge};

	always_comb begin
		if (raw_sel[RawW-1]) begin
			if (num_next > QMaxNeg)
				quot_sat = 32'h8000_0000;
			else
				quot_sat = -num_next[WordW-1:0];
		end else begin
			if (num_next > QMaxPos)
				quot_sat = 32'h7FFF_FFFF;
			else
				quot_sat = num_next[WordW-1:0];
		end
	end

	// distance term select
	always_comb begin
		case (c_q[1:0])
			2'd0:    n_sel = pl_rd_q.nx;
			2'd1:    n_sel = pl_rd_q.ny;
			default: n_sel = pl_rd_q.nz;
		endcase
		case (c_q[1:0])
			2'd0:    pt_sel = (kind_q == KIND_BOX && !n_sel[WordW-1]) ? bx_q : ax_q;
			2'd1:    pt_sel = (kind_q == KIND_BOX && !n_sel[WordW-1]) ? by_q : ay_q;
			default: pt_sel = (kind_q == KIND_BOX && !n_sel[WordW-1]) ? bz_q : az_q;
		endcase
	end

	assign mul_w = n_sel * pt_sel;

	assign sq_start = (state_q == ST_D_CHK) && (sum_q != '0);

	fct_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sum_q),
		.done     (sq_done),
		.root     (sq_root)
	);

	// memories
	always_ff @(posedge clk) begin
		if (accept && kind == KIND_LOAD)
			mat_mem[column_index] <= '{r3: a_w, r2: a_z, r1: a_y, r0: a_x};
		if (state_q == ST_D_RD)
			mat_rd_q <= mat_vld_q[c_q[1:0]] ? mat_mem[c_q[1:0]] : '0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_D_WR)
			plane_mem[p_q] <= '{d: res_q[3], nz: res_q[2], ny: res_q[1], nx: res_q[0]};
		if (state_q == ST_T_RD)
			pl_rd_q <= plane_vld_q[p_q] ? plane_mem[p_q] : '0;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mat_vld_q   <= '0;
			plane_vld_q <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (kind)
							KIND_LOAD: begin
								mat_vld_q[column_index] <= 1'b1;
								state_q <= ST_D_RD;
							end
							KIND_BOX, KIND_SPHERE: state_q <= ST_T_RD;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_D_RD:   state_q <= ST_D_RAW;
				ST_D_RAW:  state_q <= ST_D_SQ;
				ST_D_SQ:   state_q <= (c_q == 3'd3) ? ST_D_CHK : ST_D_RD;
				ST_D_CHK:  state_q <= (sum_q == '0) ? ST_D_WR : ST_D_SQRT;
				ST_D_SQRT: if (sq_done) state_q <= ST_D_DIVI;
				ST_D_DIVI: state_q <= ST_D_DIV;
				ST_D_DIV: begin
					if (cnt_q == CntW'(1))
						state_q <= (c_q == 3'd3) ? ST_D_WR : ST_D_DIVI;
				end
				ST_D_WR: begin
					plane_vld_q[p_q] <= 1'b1;
					state_q <= (p_q == 3'(NumPlanes - 1)) ? ST_IDLE : ST_D_RD;
				end
				ST_T_RD:  state_q <= ST_T_D;
				ST_T_D:   state_q <= ST_T_MUL;
				ST_T_MUL: state_q <= ST_T_ACC;
				ST_T_ACC: state_q <= (c_q == 3'd2) ? ST_T_CHK : ST_T_MUL;
				ST_T_CHK: state_q <= (p_q == 3'(NumPlanes - 1)) ? ST_EMIT : ST_T_RD;
				ST_EMIT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					kind_q <= kind;
					ax_q <= a_x; ay_q <= a_y; az_q <= a_z; aw_q <= a_w;
					bx_q <= b_x; by_q <= b_y; bz_q <= b_z;
					p_q <= '0;
					c_q <= '0;
					sum_q <= '0;
					vis_q <= 1'b1;
				end
			end
			ST_D_RAW: begin
				raw_q[c_q[1:0]] <= raw_w;
				mag_q <= raw_w[RawW-1] ? RawW'(-raw_w) : RawW'(raw_w);
			end
			ST_D_SQ: begin
				if (c_q != 3'd3)
					sum_q <= sum_q + sq_w;
				c_q <= (c_q == 3'd3) ? 3'd0 : c_q + 3'd1;
			end
			ST_D_CHK: begin
				if (sum_q == '0) begin
					for (int i = 0; i < 4; i++)
						res_q[i] <= sat_raw(raw_q[i]);
				end
			end
			ST_D_SQRT: begin
				if (sq_done) begin
					len_q <= sq_root;
					c_q <= '0;
				end
			end
			ST_D_DIVI: begin
				num_q <= (NumW'(raw_mag) << FRAC_BITS) + NumW'(len_q >> 1);
				rem_q <= '0;
				cnt_q <= CntW'(NumW);
			end
			ST_D_DIV: begin
				rem_q <= div_ge ? (rem_try - {1'b0, len_q}) : rem_try;
				num_q <= num_next;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					res_q[c_q[1:0]] <= quot_sat;
					c_q <= c_q + 3'd1;
				end
			end
			ST_D_WR: begin
				p_q <= p_q + 3'd1;
				c_q <= '0;
				sum_q <= '0;
			end
			ST_T_D: begin
				acc_q <= (AccW'(pl_rd_q.d) <<< FRAC_BITS)
					+ ((kind_q == KIND_SPHERE) ? (AccW'(aw_q) <<< FRAC_BITS) : '0);
				c_q <= '0;
			end
			ST_T_MUL: prod_q <= mul_w;
			ST_T_ACC: begin
				acc_q <= acc_q + AccW'(prod_q);
				c_q <= c_q + 3'd1;
			end
			ST_T_CHK: begin
				if (acc_q[AccW-1])
					vis_q <= 1'b0;
				p_q <= p_q + 3'd1;
			end
			ST_EMIT: begin
				visible_q   <= vis_q;
				test_kind_q <= (kind_q == KIND_SPHERE);
			end
			default: ;
		endcase
	end

	assign done      = done_q;
	assign visible   = visible_q;
	assign test_kind = test_kind_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result word while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result word repeated");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == KIND_LOAD) |=> busy)
		else $error("column load did not start derivation");

	a_test_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (kind == KIND_BOX || kind == KIND_SPHERE)) |=> !done)
		else $error("test word finished too early");

endmodule

// ----- rtl/fct_isqrt.sv -----
// ----------------------------------------------------------------------------
// fct_isqrt
// digit-by-digit integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module fct_isqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [fct_pkg::SumW-1:0]  radicand,
	output logic                      done,
	output logic [fct_pkg::LenW-1:0]  root
);
	import fct_pkg::*;

	localparam int RadW = 2 * LenW;
	localparam int RemW = LenW + 3;
	localparam int CntW = $clog2(LenW + 1);

	logic [RadW-1:0] rad_q;
	logic [RemW-1:0] rem_q;
	logic [LenW-1:0] root_q;
	logic [CntW-1:0] cnt_q;
	logic            run_q;
	logic            done_q;

	logic [RemW-1:0] rem_sh;
	logic [RemW-1:0] trial;
	logic            ge;

	assign rem_sh = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign ge     = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CntW'(LenW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= RadW'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= {rad_q[RadW-3:0], 2'b00};
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[LenW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
